// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
// Each macro wraps one clocked concurrent assertion with an active-low reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the trigger, outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/stt_pkg.sv -----
// Shared types and constants of the source text tokenizer.
// No dependencies; used by every tokenizer module.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int LINE_W   = 16;
    localparam int COLUMN_W = 16;
    localparam int LENGTH_W = 8;
    localparam int CHAR_W   = 8;
    localparam int PREFIX_W = 24;

    localparam logic [LINE_W-1:0]   LINE_MAX   = 16'd65535;
    localparam logic [COLUMN_W-1:0] COLUMN_MAX = 16'd65535;
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = 8'd255;

    localparam logic [CHAR_W-1:0] CHR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CHR_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CHR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHR_DIG0   = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_DIG9   = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CHR_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] CHR_UPA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UPZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CHR_LOA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LOZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CHR_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CHR_RBRACE = 8'h7D;

    // Keyword texts, first byte in the low bits.
    localparam logic [PREFIX_W-1:0] KW_INT = 24'h746E69;
    localparam logic [PREFIX_W-1:0] KW_IF  = 24'h006669;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_INT     = 4'd0,
        KIND_IDENT   = 4'd1,
        KIND_NUMBER  = 4'd2,
        KIND_ASSIGN  = 4'd3,
        KIND_PLUS    = 4'd4,
        KIND_MINUS   = 4'd5,
        KIND_IF      = 4'd6,
        KIND_EQUAL   = 4'd7,
        KIND_LPAREN  = 4'd8,
        KIND_RPAREN  = 4'd9,
        KIND_LBRACE  = 4'd10,
        KIND_RBRACE  = 4'd11,
        KIND_SEMI    = 4'd12,
        KIND_END     = 4'd13,
        KIND_UNKNOWN = 4'd14
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [LINE_W-1:0]   line;
        logic [COLUMN_W-1:0] column;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } t_token;

    // Tokens caused by one byte; second is valid only when the first is.
    typedef struct packed {
        logic   v0;
        t_token t0;
        logic   v1;
        t_token t1;
    } t_tok_pair;

endpackage

// ----- hw/rtl/stt_scan.sv -----
// Scanner state and token generation for one source byte per cycle while i_take is high.
// Depends on stt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [stt_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_end,
    output stt_pkg::t_tok_pair         o_pair
);

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_EQ      = 3'd3,
        MODE_SLASH   = 3'd4,
        MODE_COMMENT = 3'd5
    } t_mode;

    t_mode                          r_mode, n_mode;
    logic [stt_pkg::LINE_W-1:0]     r_line, n_line, r_sline, n_sline;
    logic [stt_pkg::COLUMN_W-1:0]   r_col, n_col, r_scol, n_scol;
    logic [stt_pkg::LENGTH_W-1:0]   r_len, n_len;
    logic [stt_pkg::PREFIX_W-1:0]   r_prefix, n_prefix;

    logic                           is_end, is_nl, is_space, is_digit, is_alpha, is_word;
    logic [stt_pkg::LINE_W-1:0]     adv_line;
    logic [stt_pkg::COLUMN_W-1:0]   adv_col;
    logic                           pend_v, a_v, b_v, do_idle, do_grow;
    stt_pkg::t_token                pend_tok, a_tok, b_tok;

    always_comb begin
        is_end   = i_end || (i_char == stt_pkg::CHR_NUL);
        is_nl    = (i_char == stt_pkg::CHR_NL);
        is_space = (i_char == stt_pkg::CHR_SPACE) ||
                   ((i_char >= stt_pkg::CHR_TAB) && (i_char <= stt_pkg::CHR_CR));
        is_digit = (i_char >= stt_pkg::CHR_DIG0) && (i_char <= stt_pkg::CHR_DIG9);
        is_alpha = ((i_char >= stt_pkg::CHR_UPA) && (i_char <= stt_pkg::CHR_UPZ)) ||
                   ((i_char >= stt_pkg::CHR_LOA) && (i_char <= stt_pkg::CHR_LOZ));
        is_word  = is_alpha || is_digit || (i_char == stt_pkg::CHR_UNDER);

        if (is_nl) begin
            adv_line = (r_line != stt_pkg::LINE_MAX) ? r_line + 1'b1 : r_line;
            adv_col  = {{(stt_pkg::COLUMN_W-1){1'b0}}, 1'b1};
        end else begin
            adv_line = r_line;
            adv_col  = (r_col != stt_pkg::COLUMN_MAX) ? r_col + 1'b1 : r_col;
        end

        pend_tok.line   = r_sline;
        pend_tok.column = r_scol;
        pend_tok.length = {{(stt_pkg::LENGTH_W-1){1'b0}}, 1'b1};
        pend_tok.last   = 1'b0;
        pend_tok.kind   = stt_pkg::KIND_UNKNOWN;
        pend_v          = 1'b0;
        unique case (r_mode)
            MODE_IDENT: begin
                pend_v          = 1'b1;
                pend_tok.length = r_len;
                if ((r_len == 8'd3) && (r_prefix == stt_pkg::KW_INT)) begin
                    pend_tok.kind = stt_pkg::KIND_INT;
                end else if ((r_len == 8'd2) && (r_prefix == stt_pkg::KW_IF)) begin
                    pend_tok.kind = stt_pkg::KIND_IF;
                end else begin
                    pend_tok.kind = stt_pkg::KIND_IDENT;
                end
            end
            MODE_NUMBER: begin
                pend_v          = 1'b1;
                pend_tok.length = r_len;
                pend_tok.kind   = stt_pkg::KIND_NUMBER;
            end
            MODE_EQ: begin
                pend_v        = 1'b1;
                pend_tok.kind = stt_pkg::KIND_ASSIGN;
            end
            MODE_SLASH: begin
                pend_v        = 1'b1;
                pend_tok.kind = stt_pkg::KIND_UNKNOWN;
            end
            default: begin
                pend_v = 1'b0;
            end
        endcase

        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_sline  = r_sline;
        n_scol   = r_scol;
        n_len    = r_len;
        n_prefix = r_prefix;
        a_v      = 1'b0;
        b_v      = 1'b0;
        a_tok    = pend_tok;
        b_tok.kind   = stt_pkg::KIND_END;
        b_tok.line   = r_line;
        b_tok.column = r_col;
        b_tok.length = '0;
        b_tok.last   = 1'b1;
        do_idle  = 1'b0;
        do_grow  = 1'b0;

        if (i_take) begin
            if (is_end) begin
                a_v      = pend_v;
                b_v      = 1'b1;
                n_mode   = MODE_IDLE;
                n_line   = {{(stt_pkg::LINE_W-1){1'b0}}, 1'b1};
                n_col    = {{(stt_pkg::COLUMN_W-1){1'b0}}, 1'b1};
                n_sline  = {{(stt_pkg::LINE_W-1){1'b0}}, 1'b1};
                n_scol   = {{(stt_pkg::COLUMN_W-1){1'b0}}, 1'b1};
                n_len    = '0;
                n_prefix = '0;
            end else begin
                unique case (r_mode)
                    MODE_IDENT: begin
                        if (is_word) do_grow = 1'b1;
                        else do_idle = 1'b1;
                    end
                    MODE_NUMBER: begin
                        if (is_digit) do_grow = 1'b1;
                        else do_idle = 1'b1;
                    end
                    MODE_EQ: begin
                        if (i_char == stt_pkg::CHR_EQUAL) begin
                            b_v          = 1'b1;
                            b_tok.kind   = stt_pkg::KIND_EQUAL;
                            b_tok.line   = r_sline;
                            b_tok.column = r_scol;
                            b_tok.length = 8'd2;
                            n_mode       = MODE_IDLE;
                            n_line       = adv_line;
                            n_col        = adv_col;
                        end else begin
                            do_idle = 1'b1;
                        end
                    end
                    MODE_SLASH: begin
                        if (i_char == stt_pkg::CHR_SLASH) begin
                            n_mode = MODE_COMMENT;
                            n_line = adv_line;
                            n_col  = adv_col;
                        end else begin
                            do_idle = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (is_nl) n_mode = MODE_IDLE;
                        n_line = adv_line;
                        n_col  = adv_col;
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_grow) begin
                    case (r_len)
                        8'd0:    n_prefix = r_prefix | {16'b0, i_char};
                        8'd1:    n_prefix = r_prefix | {8'b0, i_char, 8'b0};
                        8'd2:    n_prefix = r_prefix | {i_char, 16'b0};
                        default: n_prefix = '0;
                    endcase
                    n_len  = (r_len != stt_pkg::LENGTH_MAX) ? r_len + 1'b1 : r_len;
                    n_line = adv_line;
                    n_col  = adv_col;
                end

                if (do_idle) begin
                    a_v    = pend_v;
                    n_mode = MODE_IDLE;
                    n_line = adv_line;
                    n_col  = adv_col;
                    if (!is_space) begin
                        if (is_alpha || (i_char == stt_pkg::CHR_UNDER) || is_digit ||
                            (i_char == stt_pkg::CHR_EQUAL) || (i_char == stt_pkg::CHR_SLASH))
                        begin
                            if (is_digit) n_mode = MODE_NUMBER;
                            else if (i_char == stt_pkg::CHR_EQUAL) n_mode = MODE_EQ;
                            else if (i_char == stt_pkg::CHR_SLASH) n_mode = MODE_SLASH;
                            else n_mode = MODE_IDENT;
                            n_sline  = r_line;
                            n_scol   = r_col;
                            n_len    = {{(stt_pkg::LENGTH_W-1){1'b0}}, 1'b1};
                            n_prefix = {16'b0, i_char};
                        end else begin
                            b_v          = 1'b1;
                            b_tok.line   = r_line;
                            b_tok.column = r_col;
                            b_tok.length = {{(stt_pkg::LENGTH_W-1){1'b0}}, 1'b1};
                            case (i_char)
                                stt_pkg::CHR_PLUS:   b_tok.kind = stt_pkg::KIND_PLUS;
                                stt_pkg::CHR_MINUS:  b_tok.kind = stt_pkg::KIND_MINUS;
                                stt_pkg::CHR_LPAREN: b_tok.kind = stt_pkg::KIND_LPAREN;
                                stt_pkg::CHR_RPAREN: b_tok.kind = stt_pkg::KIND_RPAREN;
                                stt_pkg::CHR_LBRACE: b_tok.kind = stt_pkg::KIND_LBRACE;
                                stt_pkg::CHR_RBRACE: b_tok.kind = stt_pkg::KIND_RBRACE;
                                stt_pkg::CHR_SEMI:   b_tok.kind = stt_pkg::KIND_SEMI;
                                default:             b_tok.kind = stt_pkg::KIND_UNKNOWN;
                            endcase
                        end
                    end
                end
            end
        end

        o_pair.v0      = a_v || b_v;
        o_pair.t0      = a_v ? a_tok : b_tok;
        o_pair.t0.last = !(a_v && b_v);
        o_pair.v1      = a_v && b_v;
        o_pair.t1      = b_tok;
        o_pair.t1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_line   <= {{(stt_pkg::LINE_W-1){1'b0}}, 1'b1};
            r_col    <= {{(stt_pkg::COLUMN_W-1){1'b0}}, 1'b1};
            r_sline  <= {{(stt_pkg::LINE_W-1){1'b0}}, 1'b1};
            r_scol   <= {{(stt_pkg::COLUMN_W-1){1'b0}}, 1'b1};
            r_len    <= '0;
            r_prefix <= '0;
        end else begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_col    <= n_col;
            r_sline  <= n_sline;
            r_scol   <= n_scol;
            r_len    <= n_len;
            r_prefix <= n_prefix;
        end
    end

    `ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, i_take && is_end, (r_mode == MODE_IDLE) && (r_len == '0) && (r_line == 16'd1) && (r_col == 16'd1), "end of input did not return the scanner to reset")

endmodule

// ----- hw/rtl/stt_tokq.sv -----
// Four-entry token queue taking up to two tokens a cycle and giving one.
// Depends on stt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stt_tokq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stt_pkg::t_tok_pair i_pair,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output stt_pkg::t_token    o_token
);

    stt_pkg::t_token                r_mem [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [stt_pkg::QCNT_W-1:0]     r_count;
    logic [1:0]                     push_n;
    logic                           pop;
    logic [stt_pkg::QPTR_W-1:0]     wr_next;

    assign push_n  = {1'b0, i_pair.v0} + {1'b0, i_pair.v1};
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_pop;
    assign o_token = r_mem[r_rd];
    assign o_room  = (r_count <= stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH - 2));
    assign wr_next = r_wr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_pair.v0) r_mem[r_wr] <= i_pair.t0;
        if (i_pair.v1) r_mem[wr_next] <= i_pair.t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + stt_pkg::QPTR_W'(push_n);
            r_rd    <= r_rd + stt_pkg::QPTR_W'(pop);
            r_count <= r_count + stt_pkg::QCNT_W'(push_n) - stt_pkg::QCNT_W'(pop);
        end
    end

    `ASSERT_CLK(a_no_overflow, i_clk, i_rst_n, r_count <= stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH), "token queue overflow")
    `ASSERT_CLK(a_pair_order, i_clk, i_rst_n, !i_pair.v1 || i_pair.v0, "second token pushed without the first")
    `ASSERT_NEXT(a_count_track, i_clk, i_rst_n, 1'b1, r_count == $past(r_count) + stt_pkg::QCNT_W'($past(push_n)) - stt_pkg::QCNT_W'($past(pop)), "token count out of step with pushes and pops")

endmodule

// ----- hw/rtl/source_text_tokenizer.sv -----
// Source text tokenizer: byte input register, scanner and token output queue.
// One byte is taken per cycle while the queue has room; a byte waits in the input
// register and its tokens in the queue. Throughput is one byte per cycle while the
// consumer takes one word per cycle; two tokens of a byte leave the single port in turn.
// Reset is synchronous and active low, and returns line and column to one.
// Depends on stt_pkg, stt_scan and stt_tokq.
`timescale 1ns / 1ps

module source_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // token_kind, token_line, token_column, token_length
    output logic        m_axis_tlast    // last_of_run
);

    logic                       r_in_valid;
    logic [stt_pkg::CHAR_W-1:0] r_in_char;
    logic                       r_in_end;
    logic                       take, room;
    stt_pkg::t_tok_pair         pair;
    stt_pkg::t_token            tok;

    assign take          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    stt_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_char (r_in_char),
        .i_end  (r_in_end),
        .o_pair (pair)
    );

    stt_tokq u_tokq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pair (pair),
        .i_pop  (m_axis_tready),
        .o_room (room),
        .o_valid(m_axis_tvalid),
        .o_token(tok)
    );

    assign m_axis_tdata = {4'b0, tok.length, tok.column, tok.line, tok.kind};
    assign m_axis_tlast = tok.last;

endmodule
